### hw/rtl/rms_pkg.sv
// ----------------------------------------------------------------------------
// rms_pkg
// Shared types and constants of the rate-monotonic task scheduler.
// ----------------------------------------------------------------------------
package rms_pkg;

    localparam int MAX_TASKS_DEF  = 16;
    localparam int TIME_WIDTH_DEF = 32;

    localparam logic [20:0] WAIT_MAX = 21'h1FFFFF;
    localparam logic [4:0]  MISS_MAX = 5'd31;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic        action;
        logic [3:0]  slot;
        logic [7:0]  task_id;
        logic [15:0] exec_time;
        logic [15:0] period;
        logic [15:0] job_count;
    } t_in;

    typedef struct packed {
        logic [31:0] time_now;
        logic        ran;
        logic [7:0]  ran_task;
        logic        job_completed;
        logic [4:0]  missed_count;
        logic        preempted;
        logic        next_valid;
        logic [7:0]  next_task;
        logic [20:0] waiting_added;
        logic        all_done;
    } t_out;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_SCAN = 5'b00100,
        S_NEXT = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

endpackage

### hw/rtl/rms_ram.sv
// ----------------------------------------------------------------------------
// rms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/rate_monotonic_task_scheduler.sv
// ----------------------------------------------------------------------------
// rate_monotonic_task_scheduler
// After a task_count write, the first tick scans for the top job again first,
//   then runs the tick pass.
// One item in flight: a new input is taken only once the result of the last
//   one is loaded into the output register; the slot memory read port sets
//   the pace of each scan.
// Reset clears time, pending flags and the chosen job; slot memory holds junk.
// ----------------------------------------------------------------------------
module rate_monotonic_task_scheduler #(
    parameter int MAX_TASKS  = rms_pkg::MAX_TASKS_DEF,
    parameter int TIME_WIDTH = rms_pkg::TIME_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_stall,
    input  rms_pkg::t_in i_in_data,
    output logic         o_out_valid,
    input  logic         i_out_stall,
    output rms_pkg::t_out o_out_data,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [4:0]   i_cfg_data
);
    import rms_pkg::*;

    localparam int SW    = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW    = $clog2(MAX_TASKS + 1);
    localparam int TW    = TIME_WIDTH;
    localparam int VW    = TW + 1;
    localparam int REC_W = 88 + TW;

    t_state r_state, n_state;

    logic [4:0]           r_task_count;
    logic                 r_stale;
    logic [TW-1:0]        r_time;
    logic [MAX_TASKS-1:0] r_active, r_loaded;
    logic                 r_tick_mode, r_tick_after;
    logic [CW-1:0]        r_rd_cnt;
    logic                 r_p1_valid, r_p2_valid;
    logic [SW-1:0]        r_p1_idx;
    logic                 r_p2_miss;
    logic [20:0]          r_p2_wait;
    logic                 r_found;
    logic [15:0]          r_b_per, r_b_rem;
    logic [SW-1:0]        r_b_slot;
    logic [7:0]           r_b_tid;
    logic                 r_top_valid;
    logic [SW-1:0]        r_top_slot, r_cur_slot;
    logic [7:0]           r_top_tid;
    logic                 r_ran, r_completed;
    logic [7:0]           r_ran_tid;
    logic [4:0]           r_missed;
    logic [20:0]          r_wait;
    logic                 r_out_valid;
    t_out                 r_out;
    t_in                  r_in;

    logic [CW-1:0]        w_used;
    logic                 w_in_acc, w_out_acc, w_scan_done, w_rd_go;
    logic                 w_we;
    logic [SW-1:0]        w_waddr;
    logic [REC_W-1:0]     w_wdata, w_rdata, w_load_rec, w_tick_rec;

    // per-slot update of the tick pass
    logic [7:0]    c_tid;
    logic [15:0]   c_per, c_exe, c_jl, c_rem, c_cd;
    logic [TW-1:0] c_dl;
    logic          c_act, c_run, c_done, c_miss;
    logic [TW-1:0] c_el;
    logic [16:0]   c_up;
    logic [VW-1:0] c_wv;
    logic          c_better;
    logic [15:0]   l_ex, l_pe, l_jc;
    logic [21:0]   w_wsum;

    assign w_used = (int'(r_task_count) > MAX_TASKS) ? CW'(MAX_TASKS) : CW'(r_task_count);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign w_rd_go     = (r_state == S_SCAN) && (r_rd_cnt < w_used);
    assign w_scan_done = (r_state == S_SCAN) && (r_rd_cnt == w_used)
                         && !r_p1_valid && !r_p2_valid;

    rms_ram #(.WIDTH(REC_W), .DEPTH(MAX_TASKS), .AW(SW)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_rd_cnt[SW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        l_ex = (r_in.exec_time == 16'd0) ? 16'd1 : r_in.exec_time;
        l_pe = (r_in.period == 16'd0) ? 16'd1 : r_in.period;
        l_jc = (r_in.job_count == 16'd0) ? 16'd1 : r_in.job_count;
        w_load_rec = {r_time + TW'(l_pe), l_pe, l_ex, l_jc - 16'd1, l_ex, l_pe,
                      r_in.task_id};
    end

    always_comb begin
        c_tid  = w_rdata[7:0];
        c_per  = w_rdata[23:8];
        c_exe  = w_rdata[39:24];
        c_jl   = r_loaded[r_p1_idx] ? w_rdata[55:40] : 16'd0;
        c_rem  = w_rdata[71:56];
        c_cd   = w_rdata[87:72];
        c_dl   = w_rdata[REC_W-1:88];
        c_act  = r_active[r_p1_idx];
        c_run  = 1'b0;
        c_done = 1'b0;
        c_miss = 1'b0;
        c_wv   = '0;
        c_el   = r_time - c_dl + TW'(c_per);
        c_up   = '0;
        if (r_tick_mode) begin
            if (r_top_valid && r_top_slot == r_p1_idx) begin
                c_run = 1'b1;
                if (c_rem <= 16'd1) begin
                    c_done = 1'b1;
                    c_act  = 1'b0;
                    c_wv   = (c_el >= TW'(c_exe)) ? VW'(c_el - TW'(c_exe)) : '0;
                end else begin
                    c_rem = c_rem - 16'd1;
                end
            end
            if (c_act && c_dl <= r_time) begin
                c_up   = 17'(c_per) + 17'(c_rem);
                c_wv   = (c_up > 17'(c_exe)) ? VW'(c_up - 17'(c_exe)) : '0;
                c_act  = 1'b0;
                c_miss = 1'b1;
            end
            if (c_jl != 16'd0) begin
                if (c_cd > 16'd1) begin
                    c_cd = c_cd - 16'd1;
                end else begin
                    c_cd = c_per;
                    if (c_act) begin
                        c_up   = 17'(c_per) + 17'(c_rem);
                        c_wv   = (c_up > 17'(c_exe)) ? VW'(c_up - 17'(c_exe)) : '0;
                        c_miss = 1'b1;
                    end
                    c_jl  = c_jl - 16'd1;
                    c_act = 1'b1;
                    c_rem = c_exe;
                    c_dl  = r_time + TW'(c_per);
                end
            end
        end
        w_tick_rec = {c_dl, c_cd, c_rem, c_jl, c_exe, c_per, c_tid};
        c_better   = c_act && (!r_found || c_per < r_b_per
                     || (c_per == r_b_per && c_rem < r_b_rem));
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_p1_idx;
        w_wdata = w_tick_rec;
        if (r_state == S_LOAD) begin
            w_we    = (int'(r_in.slot) < MAX_TASKS);
            w_waddr = SW'(r_in.slot);
            w_wdata = w_load_rec;
        end else if (r_state == S_SCAN && r_p1_valid && r_tick_mode) begin
            w_we = 1'b1;
        end
    end

    assign w_wsum = 22'(r_wait) + 22'(r_p2_wait);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = (i_in_data.action == ACT_LOAD) ? S_LOAD : S_SCAN;
                end
            end
            S_LOAD: n_state = S_SCAN;
            S_SCAN: begin
                if (w_scan_done) begin
                    n_state = r_tick_after ? S_NEXT : S_FIN;
                end
            end
            S_NEXT: n_state = S_SCAN;
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_task_count <= 5'd1;
            r_stale      <= 1'b0;
            r_time       <= '0;
            r_active     <= '0;
            r_loaded     <= '0;
            r_tick_mode  <= 1'b0;
            r_tick_after <= 1'b0;
            r_rd_cnt     <= '0;
            r_p1_valid   <= 1'b0;
            r_p2_valid   <= 1'b0;
            r_found      <= 1'b0;
            r_top_valid  <= 1'b0;
            r_top_slot   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_task_count <= i_cfg_data;
                r_stale      <= 1'b1;
            end
            if (r_state == S_FIN && (!r_out_valid || !i_out_stall)) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    r_rd_cnt <= '0;
                    r_found  <= 1'b0;
                    if (w_in_acc) begin
                        if (i_in_data.action == ACT_TICK) begin
                            r_time       <= r_time + TW'(1);
                            r_tick_mode  <= !r_stale;
                            r_tick_after <= r_stale;
                            r_cur_slot   <= r_top_slot;
                        end else begin
                            r_tick_mode  <= 1'b0;
                            r_tick_after <= 1'b0;
                        end
                    end
                end
                S_LOAD: begin
                    if (int'(r_in.slot) < MAX_TASKS) begin
                        r_active[SW'(r_in.slot)] <= 1'b1;
                        r_loaded[SW'(r_in.slot)] <= 1'b1;
                    end
                end
                S_SCAN: begin
                    if (w_rd_go) begin
                        r_rd_cnt <= r_rd_cnt + CW'(1);
                        r_p1_idx <= r_rd_cnt[SW-1:0];
                    end
                    r_p1_valid <= w_rd_go;
                    r_p2_valid <= r_p1_valid && r_tick_mode;
                    if (r_p1_valid) begin
                        if (r_tick_mode) begin
                            r_active[r_p1_idx] <= c_act;
                        end
                        if (c_better) begin
                            r_found  <= 1'b1;
                            r_b_per  <= c_per;
                            r_b_rem  <= c_rem;
                            r_b_slot <= r_p1_idx;
                            r_b_tid  <= c_tid;
                        end
                    end
                    if (w_scan_done) begin
                        r_top_valid <= r_found;
                        r_top_slot  <= r_b_slot;
                        r_stale     <= 1'b0;
                    end
                end
                S_NEXT: begin
                    r_rd_cnt     <= '0;
                    r_found      <= 1'b0;
                    r_tick_mode  <= 1'b1;
                    r_tick_after <= 1'b0;
                    r_cur_slot   <= r_top_slot;
                end
                default: ;
            endcase
        end
    end

    // payload and per-item accumulators
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in        <= i_in_data;
            r_ran       <= 1'b0;
            r_ran_tid   <= 8'd0;
            r_completed <= 1'b0;
            r_missed    <= 5'd0;
            r_wait      <= 21'd0;
        end
        if (r_state == S_SCAN && r_p1_valid && r_tick_mode) begin
            r_p2_miss <= c_miss;
            r_p2_wait <= (c_wv > VW'(WAIT_MAX)) ? WAIT_MAX : c_wv[20:0];
            if (c_run) begin
                r_ran       <= 1'b1;
                r_ran_tid   <= c_tid;
                r_completed <= c_done;
            end
        end
        if (r_state == S_SCAN && r_p2_valid) begin
            r_wait <= (w_wsum > 22'(WAIT_MAX)) ? WAIT_MAX : w_wsum[20:0];
            if (r_p2_miss && r_missed != MISS_MAX) begin
                r_missed <= r_missed + 5'd1;
            end
        end
        if (w_scan_done) begin
            r_top_tid <= r_b_tid;
        end
        if (r_state == S_FIN && (!r_out_valid || !i_out_stall)) begin
            r_out.time_now      <= 32'(r_time);
            r_out.ran           <= r_ran;
            r_out.ran_task      <= r_ran ? r_ran_tid : 8'd0;
            r_out.job_completed <= r_completed;
            r_out.missed_count  <= r_missed;
            r_out.preempted     <= r_ran && !r_completed && r_active[r_cur_slot]
                                   && r_top_valid && (r_top_slot != r_cur_slot);
            r_out.next_valid    <= r_top_valid;
            r_out.next_task     <= r_top_valid ? r_top_tid : 8'd0;
            r_out.waiting_added <= r_wait;
            r_out.all_done      <= ~|r_active;
        end
    end

endmodule
